// ===== hw/rtl/smv_pkg.sv =====
// shared types and constants for the sparse matrix vector multiply unit
package smv_pkg;

  // payload widths
  localparam int COL_W = 6;
  localparam int ROW_W = 6;
  localparam int VAL_W = 32;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 2;

  // operation codes of an input item
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_NZ   = 2'd1;
  localparam logic [1:0] OP_EMIT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEC_LEN  = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // command to a valid bit table
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [COL_W-1:0] set_addr;
    logic [COL_W-1:0] rd_addr;
  } vld_cmd_t;

endpackage

// ===== hw/rtl/smv_if.sv =====
// item channel interfaces for input items and result items
interface smv_in_if import smv_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [COL_W-1:0]        column;
  logic [ROW_W-1:0]        row;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, column, row, value, input ready);
  modport sink (input valid, operation, column, row, value, output ready);
endinterface

interface smv_out_if import smv_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row_id;
  logic signed [VAL_W-1:0] row_sum;
  logic                    last_row;
  logic                    length_mismatch;

  modport source (output valid, row_id, row_sum, last_row, length_mismatch, input ready);
  modport sink (input valid, row_id, row_sum, last_row, length_mismatch, output ready);
endinterface

// ===== hw/rtl/sparse_csc_matrix_vector_multiply_unit.sv =====
// top level of the sparse compressed-column matrix times vector unit
//
//  channel  dir  handshake       payload
//  in_ch    in   valid / ready   operation, column, row, value
//  out_ch   out  valid / ready   row_id, row_sum, last_row, length_mismatch
//  cfg      in   cfg_we          cfg_idx, cfg_wdata
//
// a load or an ignored item finishes as it is accepted; a nonzero passes the
// states idle, mac and wb (read vector and accumulator rams, multiply, write back the sum)
// an emit goes through a read state and an output state per row, waiting on output stalls, limited by the single
// accumulator read port; a mismatch emit gives one result straight from idle
// reset clears the stores at once through valid bits, no clearing pass
// one item is worked on at a time; in_ch.ready is low until it is done
module sparse_csc_matrix_vector_multiply_unit import smv_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  smv_in_if.sink               in_ch,
  smv_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // column indexes stop at 63, so deeper vector storage is never reached
  localparam int VDEPTH = (MAX_COLS < (1 << COL_W)) ? MAX_COLS : (1 << COL_W);
  localparam int VAW = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_WB   = 5'b00100,
    S_ERD  = 5'b01000,
    S_EOUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] num_rows_r, num_cols_r, vec_len_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] prod_r, prod_nxt;
  logic [VAL_W-1:0] acc_hold_r, acc_hold_nxt;
  logic [ROW_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0] nrows_r, nrows_nxt;
  logic             last_r, last_nxt;
  logic             mm_r, mm_nxt;

  logic             in_acc, out_acc;
  logic             load_ok, nz_ok;
  logic [CFG_W-1:0] nrows_eff;
  logic [VAL_W-1:0] vdata, adata, vec_val, acc_val;
  logic             vhit, ahit;
  logic             vwe, awe;
  logic [VAW-1:0]   vwaddr, vraddr;
  logic [RAW-1:0]   awaddr, araddr;
  logic [VAL_W-1:0] awdata;
  logic [COL_W-1:0] vrd_sel;
  logic [ROW_W-1:0] ard_sel;
  logic             clr_all;
  vld_cmd_t         vcmd, acmd;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // range checks against registers and store depths
  assign load_ok = ({1'b0, in_ch.column} < vec_len_r) &&
                   ({1'b0, in_ch.column} < CFG_W'(VDEPTH));
  assign nz_ok   = ({1'b0, in_ch.column} < num_cols_r) &&
                   ({1'b0, in_ch.column} < CFG_W'(VDEPTH)) &&
                   ({1'b0, in_ch.row} < num_rows_r) &&
                   ({1'b0, in_ch.row} < CFG_W'(MAX_ROWS));
  assign nrows_eff = (num_rows_r < CFG_W'(MAX_ROWS)) ? num_rows_r : CFG_W'(MAX_ROWS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= CFG_RESET;
      num_cols_r <= CFG_RESET;
      vec_len_r  <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NUM_ROWS: num_rows_r <= cfg_wdata;
        CFG_NUM_COLS: num_cols_r <= cfg_wdata;
        CFG_VEC_LEN:  vec_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // never written entries read as zero
  assign vec_val = vhit ? vdata : '0;
  assign acc_val = ahit ? adata : '0;

  // control sequencer
  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    val_nxt      = val_r;
    prod_nxt     = prod_r;
    acc_hold_nxt = acc_hold_r;
    cnt_nxt      = cnt_r;
    nrows_nxt    = nrows_r;
    last_nxt     = last_r;
    mm_nxt       = mm_r;
    vwe          = 1'b0;
    awe          = 1'b0;
    clr_all      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.operation)
            OP_LOAD: begin
              vwe = load_ok;
            end
            OP_NZ: begin
              if (nz_ok) begin
                row_nxt   = in_ch.row;
                val_nxt   = in_ch.value;
                state_nxt = S_MAC;
              end
            end
            OP_EMIT: begin
              cnt_nxt   = '0;
              nrows_nxt = nrows_eff;
              if (num_cols_r != vec_len_r) begin
                mm_nxt    = 1'b1;
                last_nxt  = 1'b1;
                state_nxt = S_EOUT;
              end else if (nrows_eff == '0) begin
                clr_all = 1'b1;
              end else begin
                mm_nxt    = 1'b0;
                last_nxt  = (nrows_eff == CFG_W'(1));
                state_nxt = S_ERD;
              end
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        prod_nxt     = val_r * vec_val;
        acc_hold_nxt = acc_val;
        state_nxt    = S_WB;
      end
      S_WB: begin
        awe       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (out_acc) begin
          if (last_r) begin
            clr_all   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + ROW_W'(1);
            last_nxt  = ({1'b0, cnt_r} + CFG_W'(2)) == nrows_r;
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      mm_r    <= 1'b0;
      nrows_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      mm_r    <= mm_nxt;
      nrows_r <= nrows_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    val_r      <= val_nxt;
    prod_r     <= prod_nxt;
    acc_hold_r <= acc_hold_nxt;
  end

  // ram addressing: nonzero reads issued from the item as it is accepted, emit reads from the row counter
  assign vrd_sel = nz_ok ? in_ch.column : '0;
  always_comb begin
    ard_sel = '0;
    case (state_r)
      S_IDLE:  ard_sel = nz_ok ? in_ch.row : '0;
      S_ERD:   ard_sel = cnt_r;
      S_EOUT:  ard_sel = cnt_r;
      default: ard_sel = row_r;
    endcase
  end

  assign vwaddr = load_ok ? in_ch.column[VAW-1:0] : '0;
  assign vraddr = vrd_sel[VAW-1:0];
  assign awaddr = row_r[RAW-1:0];
  assign araddr = ard_sel[RAW-1:0];
  assign awdata = acc_hold_r + prod_r;

  smv_ram #(.W(VAL_W), .D(VDEPTH)) u_vec_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (in_ch.value),
    .raddr (vraddr),
    .rdata (vdata)
  );

  smv_ram #(.W(VAL_W), .D(MAX_ROWS)) u_acc_ram (
    .clk   (clk),
    .we    (awe),
    .waddr (awaddr),
    .wdata (awdata),
    .raddr (araddr),
    .rdata (adata)
  );

  // valid bits stand in for clearing the rams
  always_comb begin
    vcmd          = '0;
    vcmd.set      = vwe;
    vcmd.clr      = clr_all;
    vcmd.set_addr = load_ok ? in_ch.column : '0;
    vcmd.rd_addr  = vrd_sel;
    acmd          = '0;
    acmd.set      = awe;
    acmd.clr      = clr_all;
    acmd.set_addr = row_r;
    acmd.rd_addr  = ard_sel;
  end

  smv_vld #(.DEPTH(VDEPTH)) u_vec_vld (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (vcmd),
    .hit   (vhit)
  );

  smv_vld #(.DEPTH(MAX_ROWS)) u_acc_vld (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (acmd),
    .hit   (ahit)
  );

  // channel outputs
  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = (state_r == S_EOUT);
  assign out_ch.row_id          = cnt_r;
  assign out_ch.row_sum         = mm_r ? '0 : acc_val;
  assign out_ch.last_row        = last_r;
  assign out_ch.length_mismatch = mm_r;

  // no new item while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while result pending");

  // a mismatch result is alone and carries a zero sum
  a_mismatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.length_mismatch) |-> (out_ch.last_row && out_ch.row_sum == '0
      && out_ch.row_id == '0))
    else $error("malformed mismatch result");

  // accumulator write back only after a multiply step
  a_wb_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
    awe |-> $past(state_r == S_MAC))
    else $error("accumulator write without multiply");

  // row id steps by one within an emit run
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_ch.last_row) |=> ##1 (out_ch.valid &&
      out_ch.row_id == $past(out_ch.row_id, 2) + ROW_W'(1)))
    else $error("row id out of sequence");

endmodule

// ===== hw/rtl/smv_ram.sv =====
// generic single write, single read ram with registered read data
module smv_ram #(
  parameter int W = 32,
  parameter int D = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/smv_vld.sv =====
// valid bit table that makes never written ram entries read as zero
module smv_vld import smv_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  vld_cmd_t cmd,
  output logic     hit
);

  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             hit_r;

  // set one bit or clear all of them
  always_comb begin
    vld_nxt = vld_r;
    if (cmd.clr) begin
      vld_nxt = '0;
    end else if (cmd.set) begin
      vld_nxt[cmd.set_addr[AW-1:0]] = 1'b1;
    end
  end

  // lookup registered to line up with the ram read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      hit_r <= vld_r[cmd.rd_addr[AW-1:0]];
    end
  end

  assign hit = hit_r;

endmodule

// ===== verif/tb_sparse_csc_matrix_vector_multiply_unit.sv =====
// self-checking testbench for the sparse csc matrix times vector unit with its own row-sum predictor
module tb_sparse_csc_matrix_vector_multiply_unit import smv_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STORE_DEPTH   = 64;
  localparam int          TAIL_CYCLES   = 32;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          MAX_REPORTS   = 200;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // one row result as the unit should deliver it
  typedef struct {
    logic [ROW_W-1:0] row_id;
    logic [VAL_W-1:0] row_sum;
    logic             last_row;
    logic             length_mismatch;
  } row_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  smv_in_if  in_ch ();
  smv_out_if out_ch ();

  sparse_csc_matrix_vector_multiply_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: vector image, row sums and register copies
  logic [VAL_W-1:0] vec_image [STORE_DEPTH];
  logic [VAL_W-1:0] row_sums  [STORE_DEPTH];
  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  logic [CFG_W-1:0] vlen_cfg;

  row_result_t expected_rows [$];

  int src_idle_pct;
  int snk_idle_pct;
  int fail_count;
  int items_sent;
  int items_effective;
  int emits_sent;
  int rows_checked;
  int cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d row results outstanding",
               cycle_count, expected_rows.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  function automatic void note_fail();
    fail_count++;
  endfunction

  // compare each result item against the oldest predicted row
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rows_checked++;
      if (expected_rows.size() == 0) begin
        note_fail();
        if (fail_count <= MAX_REPORTS)
          $error("unexpected result item: row_id %0d row_sum %0d",
                 out_ch.row_id, out_ch.row_sum);
      end else begin
        want = expected_rows.pop_front();
        if (out_ch.row_id !== want.row_id) begin
          note_fail();
          if (fail_count <= MAX_REPORTS)
            $error("row_id: expected %0d, got %0d", want.row_id, out_ch.row_id);
        end
        if (out_ch.row_sum !== want.row_sum) begin
          note_fail();
          if (fail_count <= MAX_REPORTS)
            $error("row_sum (row %0d): expected %0d, got %0d", want.row_id,
                   $signed(want.row_sum), out_ch.row_sum);
        end
        if (out_ch.last_row !== want.last_row) begin
          note_fail();
          if (fail_count <= MAX_REPORTS)
            $error("last_row (row %0d): expected %0b, got %0b", want.row_id,
                   want.last_row, out_ch.last_row);
        end
        if (out_ch.length_mismatch !== want.length_mismatch) begin
          note_fail();
          if (fail_count <= MAX_REPORTS)
            $error("length_mismatch (row %0d): expected %0b, got %0b", want.row_id,
                   want.length_mismatch, out_ch.length_mismatch);
        end
      end
    end
  end

  // clear both predictor stores
  function automatic void clear_images();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      vec_image[i] = '0;
      row_sums[i]  = '0;
    end
  endfunction

  // advance the predictor by one accepted item and queue its row results
  function automatic void predict_item(logic [1:0] op, logic [COL_W-1:0] col,
                                       logic [ROW_W-1:0] row, logic [VAL_W-1:0] val);
    logic [VAL_W-1:0] prod;
    int               n_rows;
    row_result_t      res;
    case (op)
      OP_LOAD: begin
        if (col < vlen_cfg) begin
          vec_image[col] = val;
          items_effective++;
        end
      end
      OP_NZ: begin
        if (col < cols_cfg && row < rows_cfg) begin
          prod = val * vec_image[col];
          row_sums[row] = row_sums[row] + prod;
          items_effective++;
        end
      end
      OP_EMIT: begin
        items_effective++;
        emits_sent++;
        if (cols_cfg != vlen_cfg) begin
          res.row_id          = '0;
          res.row_sum         = '0;
          res.last_row        = 1'b1;
          res.length_mismatch = 1'b1;
          expected_rows.push_back(res);
        end else begin
          n_rows = (rows_cfg < STORE_DEPTH) ? int'(rows_cfg) : STORE_DEPTH;
          for (int i = 0; i < n_rows; i++) begin
            res.row_id          = i[ROW_W-1:0];
            res.row_sum         = row_sums[i];
            res.last_row        = (i == n_rows - 1);
            res.length_mismatch = 1'b0;
            expected_rows.push_back(res);
          end
        end
        clear_images();
      end
      default: ;
    endcase
  endfunction

  // send one item, idling before it at random
  task automatic send_item(logic [1:0] op, logic [COL_W-1:0] col,
                           logic [ROW_W-1:0] row, logic [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.column    <= col;
    in_ch.row       <= row;
    in_ch.value     <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    predict_item(op, col, row, val);
  endtask

  // stop sending and wait until every predicted row has come back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // one register write; the unit must be idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_NUM_ROWS: rows_cfg = data;
      CFG_NUM_COLS: cols_cfg = data;
      CFG_VEC_LEN:  vlen_cfg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                            logic [CFG_W-1:0] vlen);
    settle();
    write_reg(CFG_NUM_ROWS, rows);
    write_reg(CFG_NUM_COLS, cols);
    write_reg(CFG_VEC_LEN, vlen);
  endtask

  // index mostly inside the configured range, sometimes anywhere
  function automatic logic [5:0] pick_index(int unsigned limit);
    int unsigned lim;
    lim = (limit < STORE_DEPTH) ? limit : STORE_DEPTH;
    if (lim > 0 && $urandom_range(0, 99) < 85)
      return 6'($urandom_range(0, lim - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // all rows zero straight after reset, default registers
  task automatic test_default_emit();
    send_item(OP_EMIT, 6'd0, 6'd0, 32'd0);
  endtask

  // extreme positions and values, overwrite of a vector element, unused operation
  task automatic test_value_extremes();
    send_item(OP_LOAD, 6'd0,  6'd0,  32'h8000_0000);
    send_item(OP_LOAD, 6'd63, 6'd0,  32'h7fff_ffff);
    send_item(OP_LOAD, 6'd63, 6'd63, 32'hffff_ffff);
    send_item(OP_NZ,   6'd0,  6'd0,  32'h8000_0000);
    send_item(OP_NZ,   6'd63, 6'd63, 32'h7fff_ffff);
    send_item(OP_NZ,   6'd63, 6'd63, 32'hffff_ffff);
    send_item(OP_NZ,   6'd0,  6'd63, 32'h0000_0001);
    send_item(OP_UNUSED, 6'd63, 6'd63, 32'hffff_ffff);
    send_item(OP_EMIT, 6'd63, 6'd63, 32'hffff_ffff);
  endtask

  // loads and nonzeros just past the configured sizes are dropped
  task automatic test_out_of_range();
    set_config(7'd8, 7'd5, 7'd5);
    send_item(OP_LOAD, 6'd5,  6'd0, 32'd9);
    send_item(OP_LOAD, 6'd4,  6'd0, 32'd3);
    send_item(OP_LOAD, 6'd63, 6'd0, 32'd11);
    send_item(OP_NZ,   6'd4,  6'd8, 32'd5);
    send_item(OP_NZ,   6'd5,  6'd0, 32'd5);
    send_item(OP_NZ,   6'd4,  6'd7, 32'd2);
    send_item(OP_EMIT, 6'd0,  6'd0, 32'd0);
  endtask

  // column count differs from vector length; stores are cleared anyway
  task automatic test_length_mismatch();
    set_config(7'd4, 7'd5, 7'd6);
    send_item(OP_LOAD, 6'd1, 6'd0, 32'd5);
    send_item(OP_NZ,   6'd1, 6'd0, 32'd3);
    send_item(OP_EMIT, 6'd0, 6'd0, 32'd0);
    settle();
    write_reg(CFG_VEC_LEN, 7'd5);
    send_item(OP_EMIT, 6'd0, 6'd0, 32'd0);
  endtask

  // zero rows, row count beyond the store, single row
  task automatic test_row_count_limits();
    set_config(7'd0, 7'd64, 7'd64);
    send_item(OP_LOAD, 6'd2, 6'd0, 32'd7);
    send_item(OP_EMIT, 6'd0, 6'd0, 32'd0);
    settle();
    write_reg(CFG_NUM_ROWS, 7'd127);
    send_item(OP_LOAD, 6'd2, 6'd0,  32'd7);
    send_item(OP_NZ,   6'd2, 6'd63, 32'd3);
    send_item(OP_EMIT, 6'd0, 6'd0,  32'd0);
    settle();
    write_reg(CFG_NUM_ROWS, 7'd1);
    send_item(OP_EMIT, 6'd0, 6'd0, 32'd0);
  endtask

  // a write to the spare register index changes nothing
  task automatic test_unused_register_index();
    set_config(7'd3, 7'd4, 7'd4);
    write_reg(CFG_UNUSED_IDX, 7'd0);
    send_item(OP_EMIT, 6'd0, 6'd0, 32'd0);
  endtask

  // one random matrix: new sizes, vector loads, nonzeros with some noise, emit
  task automatic random_matrix_run();
    int unsigned rows;
    int unsigned cols;
    int unsigned vlen;
    int unsigned pick;
    int unsigned n_loads;
    int unsigned n_nz;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 40)      rows = $urandom_range(1, 8);
    else if (pick < 60) rows = 64;
    else if (pick < 70) rows = 1;
    else if (pick < 90) rows = $urandom_range(1, 64);
    else if (pick < 95) rows = 0;
    else                rows = $urandom_range(65, 127);
    pick = $urandom_range(0, 99);
    if (pick < 30)      cols = 64;
    else if (pick < 40) cols = 1;
    else if (pick < 95) cols = $urandom_range(1, 64);
    else                cols = $urandom_range(65, 127);
    vlen = ($urandom_range(0, 99) < 90) ? cols : $urandom_range(1, 64);
    set_config(7'(rows), 7'(cols), 7'(vlen));

    n_loads = $urandom_range(1, 8);
    repeat (n_loads)
      send_item(OP_LOAD, pick_index(vlen), 6'($urandom_range(0, 63)), pick_value());
    n_nz = $urandom_range(1, 10);
    repeat (n_nz) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       op = OP_UNUSED;
      else if (pick < 20) op = OP_LOAD;
      else                op = OP_NZ;
      send_item(op, pick_index((op == OP_LOAD) ? vlen : cols), pick_index(rows),
                pick_value());
    end
    send_item(OP_EMIT, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), $urandom());
  endtask

  task automatic test_random_traffic(int src_pct, int snk_pct, int n_items);
    int target;
    settle();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    target = items_sent + n_items;
    while (items_sent < target) random_matrix_run();
  endtask

  // main sequence
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.column    = '0;
    in_ch.row       = '0;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    src_idle_pct    = 16;
    snk_idle_pct    = 77;
    fail_count      = 0;
    items_sent      = 0;
    items_effective = 0;
    emits_sent      = 0;
    rows_checked    = 0;
    rows_cfg        = CFG_RESET;
    cols_cfg        = CFG_RESET;
    vlen_cfg        = CFG_RESET;
    clear_images();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_emit();
    test_value_extremes();
    test_out_of_range();
    test_length_mismatch();
    test_row_count_limits();
    test_unused_register_index();
    test_random_traffic(16, 77, 28);
    test_random_traffic(77, 16, 28);
    test_random_traffic(0, 0, 28);
    settle();

    $display("sent %0d items (%0d with effect), %0d emits, %0d row results checked",
             items_sent, items_effective, emits_sent, rows_checked);
    $display("three idle profiles, register extremes, mismatch and out-of-range cases");
    if (fail_count == 0 && expected_rows.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
